@@ hdl/crro_pkg.sv @@
// ----------------------------------------------------------------------------
// crro_pkg: shared constants and types for the circle / rotated rect test
// Widths of the coordinate and trig datapaths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package crro_pkg;

  localparam int unsigned CoordBits  = 24;
  localparam int unsigned TrigBits   = 16;
  localparam int unsigned SizeBits   = CoordBits - 1;
  localparam int unsigned CordSteps  = 30;
  localparam int unsigned CordW      = 34;   // x, y magnitude stays below 2^31
  localparam int unsigned AngW       = 33;
  localparam int unsigned DblW       = CoordBits + 3;  // doubled units, spare bits
  localparam int unsigned CordStepsPerStage = 6;
  localparam int unsigned CordStages = CordSteps / CordStepsPerStage;
  localparam logic signed [CordW-1:0] CordOne = CordW'(652032874);

  typedef logic signed [CordW-1:0] cord_t;
  typedef logic signed [AngW-1:0]  ang_t;
  typedef logic signed [DblW-1:0]  dbl_t;

  // Geometry carried alongside the CORDIC stages.
  typedef struct packed {
    dbl_t                 dx;
    dbl_t                 dy;
    dbl_t                 mx;
    dbl_t                 my;
    dbl_t                 lo_x;
    dbl_t                 lo_y;
    dbl_t                 hi_x;
    dbl_t                 hi_y;
    logic [SizeBits-1:0]  diam;
  } geom_t;

  typedef struct packed {
    cord_t x;
    cord_t y;
    ang_t  z;
    logic  flip;
  } cord_st_t;

  function automatic ang_t atan_turn(input int unsigned i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return AngW'(signed'({1'b0, t}));
  endfunction

endpackage

@@ hdl/crro_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// crro_cordic_stage: one registered group of CORDIC rotation steps
// Applies CordStepsPerStage micro-rotations starting at step FirstStep.
// ----------------------------------------------------------------------------
module crro_cordic_stage
  import crro_pkg::*;
#(
  parameter int unsigned FirstStep = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  cord_st_t st_i,
  input  geom_t    geom_i,
  output logic     valid_o,
  output cord_st_t st_o,
  output geom_t    geom_o
);

  cord_st_t st_d, st_q;
  geom_t    geom_q;
  logic     valid_q;

  always_comb begin
    cord_t xs, ys;
    st_d = st_i;
    for (int unsigned k = 0; k < CordStepsPerStage; k++) begin
      xs = st_d.x >>> (FirstStep + k);
      ys = st_d.y >>> (FirstStep + k);
      if (!st_d.z[AngW-1]) begin
        st_d.x = st_d.x - ys;
        st_d.y = st_d.y + xs;
        st_d.z = st_d.z - atan_turn(FirstStep + k);
      end else begin
        st_d.x = st_d.x + ys;
        st_d.y = st_d.y - xs;
        st_d.z = st_d.z + atan_turn(FirstStep + k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q   <= st_d;
    geom_q <= geom_i;
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign geom_o  = geom_q;

endmodule

@@ hdl/crro_backend.sv @@
// ----------------------------------------------------------------------------
// crro_backend: rotate, clamp and distance compare
// Six register stages: trig rounding, products, rotate and clamp, magnitudes,
// squares, compare.
// ----------------------------------------------------------------------------
module crro_backend
  import crro_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  cord_st_t st_i,
  input  geom_t    geom_i,
  output logic     valid_o,
  output logic     overlap_o
);

  localparam int unsigned RoundSh = 30 - (TrigBits - 1);
  localparam int unsigned TW      = TrigBits;
  localparam int unsigned PW      = DblW + TW + 1;
  localparam int unsigned RW      = DblW + 2;
  localparam int unsigned SqW     = 2 * SizeBits + 1;

  typedef logic signed [TW-1:0] trig_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [RW-1:0] rot_t;

  function automatic trig_t trig_round(input cord_t v);
    cord_t r;
    r = (v + cord_t'(1 << (RoundSh - 1))) >>> RoundSh;
    if (r > cord_t'((1 << (TW - 1)) - 1)) begin
      return trig_t'((1 << (TW - 1)) - 1);
    end else if (r < -cord_t'(1 << (TW - 1))) begin
      return trig_t'(-(1 << (TW - 1)));
    end
    return trig_t'(r);
  endfunction

  // stage A: round trig
  logic  va_q;
  trig_t sn_q, cs_q;
  geom_t ga_q;
  cord_t cx, cy;
  assign cx = st_i.flip ? -st_i.x : st_i.x;
  assign cy = st_i.flip ? -st_i.y : st_i.y;

  // stage B: four products
  logic  vb_q;
  prod_t cdx_q, sdy_q, sdx_q, cdy_q;
  geom_t gb_q;

  // stage C: sums, shift, clamp
  logic  vc_q;
  rot_t  ex_d, ey_d, ex_q, ey_q;
  logic [SizeBits-1:0] dc_q;

  always_comb begin
    prod_t sx, sy;
    rot_t  rx, ry;
    sx = cdx_q - sdy_q + prod_t'(1 << (TW - 2));
    sy = sdx_q + cdy_q + prod_t'(1 << (TW - 2));
    rx = rot_t'(sx >>> (TW - 1)) + rot_t'(gb_q.mx);
    ry = rot_t'(sy >>> (TW - 1)) + rot_t'(gb_q.my);
    if (rx < rot_t'(gb_q.lo_x))      ex_d = rx - rot_t'(gb_q.lo_x);
    else if (rx > rot_t'(gb_q.hi_x)) ex_d = rx - rot_t'(gb_q.hi_x);
    else                             ex_d = '0;
    if (ry < rot_t'(gb_q.lo_y))      ey_d = ry - rot_t'(gb_q.lo_y);
    else if (ry > rot_t'(gb_q.hi_y)) ey_d = ry - rot_t'(gb_q.hi_y);
    else                             ey_d = '0;
  end

  // stage D: magnitudes and near test
  logic vd_q, near_q;
  logic [SizeBits-1:0] ux_q, uy_q, dd_q;
  rot_t ax, ay;
  assign ax = ex_q[RW-1] ? -ex_q : ex_q;
  assign ay = ey_q[RW-1] ? -ey_q : ey_q;

  // stage E: squares
  logic ve_q, ne_q;
  logic [SqW-2:0] sx_q, sy_q, sd_q;

  // stage F: compare
  logic vf_q, hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0; vb_q <= 1'b0; vc_q <= 1'b0;
      vd_q <= 1'b0; ve_q <= 1'b0; vf_q <= 1'b0;
    end else begin
      va_q <= valid_i; vb_q <= va_q; vc_q <= vb_q;
      vd_q <= vc_q;    ve_q <= vd_q; vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sn_q   <= trig_round(cy);
    cs_q   <= trig_round(cx);
    ga_q   <= geom_i;
    cdx_q  <= prod_t'(cs_q) * prod_t'(ga_q.dx);
    sdy_q  <= prod_t'(sn_q) * prod_t'(ga_q.dy);
    sdx_q  <= prod_t'(sn_q) * prod_t'(ga_q.dx);
    cdy_q  <= prod_t'(cs_q) * prod_t'(ga_q.dy);
    gb_q   <= ga_q;
    ex_q   <= ex_d;
    ey_q   <= ey_d;
    dc_q   <= gb_q.diam;
    near_q <= (ax < rot_t'({1'b0, dc_q})) && (ay < rot_t'({1'b0, dc_q}));
    ux_q   <= ax[SizeBits-1:0];
    uy_q   <= ay[SizeBits-1:0];
    dd_q   <= dc_q;
    ne_q   <= near_q;
    sx_q   <= (SqW-1)'(ux_q) * (SqW-1)'(ux_q);
    sy_q   <= (SqW-1)'(uy_q) * (SqW-1)'(uy_q);
    sd_q   <= (SqW-1)'(dd_q) * (SqW-1)'(dd_q);
    hit_q  <= ne_q && ((SqW'(sx_q) + SqW'(sy_q)) < SqW'(sd_q));
  end

  assign valid_o   = vf_q;
  assign overlap_o = hit_q;

endmodule

@@ hdl/circle_rotated_rect_overlap.sv @@
// ----------------------------------------------------------------------------
// circle_rotated_rect_overlap: circle versus rotated rectangle overlap test
// Pipelined fixed-point query: CORDIC sin/cos, rotate, clamp, distance compare.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the circle and rectangle fields with start_i high for one cycle to
//   issue a request. busy_o is always low, so a request is taken every cycle.
//   Each request yields exactly one result: overlap_o, qualified by
//   done_o for a single cycle. Results leave in request order.
// Pipeline: twelve register stages (one input stage, five CORDIC stages of
//   six micro-rotations each, six back-end stages: trig round, products,
//   rotate and clamp, magnitudes, squares, compare).
// Throughput: one request per cycle; set by the fully pipelined CORDIC.
// Reset: rst_ni clears all valid bits; requests in flight are dropped.
// The receiver cannot stall: done_o is a pure strobe and nothing is held.
// ----------------------------------------------------------------------------
module circle_rotated_rect_overlap
  import crro_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [CoordBits-1:0] circle_center_x_i,
  input  logic signed [CoordBits-1:0] circle_center_y_i,
  input  logic [SizeBits-1:0]         circle_diameter_i,
  input  logic signed [CoordBits-1:0] rect_left_i,
  input  logic signed [CoordBits-1:0] rect_top_i,
  input  logic [SizeBits-1:0]         rect_width_i,
  input  logic [SizeBits-1:0]         rect_height_i,
  input  logic [TrigBits-1:0]         rect_angle_i,
  output logic                        done_o,
  output logic                        overlap_o
);

  // Never hold off a request: the pipeline advances every cycle.
  assign busy_o = 1'b0;

  logic     v0_q;
  cord_st_t st0_q;
  geom_t    g0_q;
  cord_st_t st0_d;
  geom_t    g0_d;

  always_comb begin
    logic [31:0] a;
    logic        flip;
    dbl_t        mx, my, lx, ly;
    a    = {rect_angle_i, {(32 - TrigBits){1'b0}}};
    // second and third quadrant: fold by half a turn, negate results later
    flip = a[31] ^ a[30];
    if (flip) a[31] = ~a[31];
    st0_d.x    = CordOne;
    st0_d.y    = '0;
    st0_d.z    = AngW'(signed'(a));
    st0_d.flip = flip;
    lx = dbl_t'(rect_left_i) <<< 1;
    ly = dbl_t'(rect_top_i) <<< 1;
    mx = lx + dbl_t'({1'b0, rect_width_i});
    my = ly + dbl_t'({1'b0, rect_height_i});
    g0_d.dx   = (dbl_t'(circle_center_x_i) <<< 1) - mx;
    g0_d.dy   = (dbl_t'(circle_center_y_i) <<< 1) - my;
    g0_d.mx   = mx;
    g0_d.my   = my;
    g0_d.lo_x = lx;
    g0_d.lo_y = ly;
    g0_d.hi_x = lx + (dbl_t'({1'b0, rect_width_i}) <<< 1);
    g0_d.hi_y = ly + (dbl_t'({1'b0, rect_height_i}) <<< 1);
    g0_d.diam = circle_diameter_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    st0_q <= st0_d;
    g0_q  <= g0_d;
  end

  // CORDIC chain: valid bits travel with each stage.
  logic     cv [CordStages+1];
  cord_st_t cs [CordStages+1];
  geom_t    cg [CordStages+1];

  assign cv[0] = v0_q;
  assign cs[0] = st0_q;
  assign cg[0] = g0_q;

  for (genvar s = 0; s < CordStages; s++) begin : g_cordic
    crro_cordic_stage #(
      .FirstStep(s * CordStepsPerStage)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[s]),
      .st_i    (cs[s]),
      .geom_i  (cg[s]),
      .valid_o (cv[s+1]),
      .st_o    (cs[s+1]),
      .geom_o  (cg[s+1])
    );
  end

  crro_backend u_backend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (cv[CordStages]),
    .st_i      (cs[CordStages]),
    .geom_i    (cg[CordStages]),
    .valid_o   (done_o),
    .overlap_o (overlap_o)
  );

  // A request shows up as a strobe after the full pipeline depth.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q |-> ##11 done_o) else $error("request lost in pipeline");
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(v0_q, 11)) else $error("result without request");
  a_zero_diam: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && circle_diameter_i == '0) |-> ##12 !overlap_o)
    else $error("zero diameter overlaps");

endmodule

@@ bench/circle_rotated_rect_overlap_chk.sv @@
// ----------------------------------------------------------------------------
// circle_rotated_rect_overlap_chk: overlap predictor and result checker
// Watches accepted requests, computes the expected overlap flag in fixed point
// and compares each done strobe with the oldest pending prediction.
// ----------------------------------------------------------------------------
module circle_rotated_rect_overlap_chk
  import crro_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic signed [CoordBits-1:0] circle_center_x_i,
  input  logic signed [CoordBits-1:0] circle_center_y_i,
  input  logic [SizeBits-1:0]         circle_diameter_i,
  input  logic signed [CoordBits-1:0] rect_left_i,
  input  logic signed [CoordBits-1:0] rect_top_i,
  input  logic [SizeBits-1:0]         rect_width_i,
  input  logic [SizeBits-1:0]         rect_height_i,
  input  logic [TrigBits-1:0]         rect_angle_i,
  input  logic                        done_i,
  input  logic                        overlap_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          hits_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint UnitOne = 652032874;

  bit overlap_q[$];
  int mismatches;

  function automatic longint arc_step(input int i);
    longint t [0:29];
    t = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
          64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
          64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
          64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
          64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
          64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
    return t[i];
  endfunction

  // Round a Q2.30 CORDIC output down to Q1.(TrigBits-1) and saturate.
  function automatic longint round_trig(input longint v);
    longint r, lim;
    lim = (longint'(1) <<< (TrigBits - 1)) - 1;
    r = (v + (longint'(1) <<< (30 - TrigBits))) >>> (31 - TrigBits);
    if (r > lim) r = lim;
    if (r < -lim - 1) r = -lim - 1;
    return r;
  endfunction

  function automatic bit predict_overlap(
    input longint px, input longint py, input longint diam, input longint left,
    input longint top, input longint wid, input longint hgt,
    input logic [TrigBits-1:0] ang);
    logic [31:0] turn;
    bit flip;
    longint x, y, z, xs, ys, sn, cs, mx, my, dx, dy, rx, ry, lo, hi, ex, ey;
    turn = {ang, {(32 - TrigBits){1'b0}}};
    flip = (turn[31:30] == 2'd1) || (turn[31:30] == 2'd2);
    if (flip) turn[31] = ~turn[31];
    z = longint'(signed'(turn));
    x = UnitOne;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arc_step(i);
      end else begin
        x += ys; y -= xs; z += arc_step(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cs = round_trig(x);
    sn = round_trig(y);
    mx = 2 * left + wid;
    my = 2 * top + hgt;
    dx = 2 * px - mx;
    dy = 2 * py - my;
    rx = ((cs * dx - sn * dy + (longint'(1) <<< (TrigBits - 2))) >>> (TrigBits - 1)) + mx;
    ry = ((sn * dx + cs * dy + (longint'(1) <<< (TrigBits - 2))) >>> (TrigBits - 1)) + my;
    lo = 2 * left; hi = 2 * left + 2 * wid;
    ex = (rx < lo) ? rx - lo : (rx > hi) ? rx - hi : 0;
    lo = 2 * top; hi = 2 * top + 2 * hgt;
    ey = (ry < lo) ? ry - lo : (ry > hi) ? ry - hi : 0;
    if (ex < 0) ex = -ex;
    if (ey < 0) ey = -ey;
    // Far apart on either axis: no overlap, and squares are never formed.
    if (ex >= diam || ey >= diam) return 1'b0;
    return (ex * ex + ey * ey) < (diam * diam);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mismatches <= 0;
      hits_seen_o <= 0;
    end else begin
      if (start_i && !busy_i) begin
        overlap_q.push_back(predict_overlap(
          circle_center_x_i, circle_center_y_i, circle_diameter_i, rect_left_i,
          rect_top_i, rect_width_i, rect_height_i, rect_angle_i));
      end
      if (done_i) begin
        if (overlap_q.size() == 0) begin
          if (mismatches < 10) $display("ERROR: unexpected result overlap=%0b", overlap_i);
          mismatches <= mismatches + 1;
        end else begin
          if (overlap_q[0] !== overlap_i) begin
            if (mismatches < 10)
              $display("ERROR: overlap expected %0b got %0b", overlap_q[0], overlap_i);
            mismatches <= mismatches + 1;
          end
          if (overlap_i === 1'b1) hits_seen_o <= hits_seen_o + 1;
          void'(overlap_q.pop_front());
        end
      end
    end
  end

  assign fail_count_o = mismatches;
  assign pending_o = overlap_q.size();

endmodule

@@ bench/circle_rotated_rect_overlap_tb.sv @@
// ----------------------------------------------------------------------------
// circle_rotated_rect_overlap_tb: stimulus and verdict for the overlap test
// Directed corner requests, then bursty random requests mostly built so the
// circle sits near the rectangle; a checker module predicts every result.
// ----------------------------------------------------------------------------
module circle_rotated_rect_overlap_tb;
  import crro_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 12;
  localparam int RandomRequests = 800;
  localparam int CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, done_o, overlap_o;
  logic signed [CoordBits-1:0] cx_i = '0, cy_i = '0, left_i = '0, top_i = '0;
  logic [SizeBits-1:0] diam_i = '0, wid_i = '0, hgt_i = '0;
  logic [TrigBits-1:0] ang_i = '0;
  int fail_count, pending, hits_seen, issued;
  int cycles = 0;

  always #10 clk_i = ~clk_i;

  circle_rotated_rect_overlap u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .circle_center_x_i(cx_i), .circle_center_y_i(cy_i), .circle_diameter_i(diam_i),
    .rect_left_i(left_i), .rect_top_i(top_i), .rect_width_i(wid_i),
    .rect_height_i(hgt_i), .rect_angle_i(ang_i), .done_o, .overlap_o
  );

  circle_rotated_rect_overlap_chk u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o),
    .circle_center_x_i(cx_i), .circle_center_y_i(cy_i), .circle_diameter_i(diam_i),
    .rect_left_i(left_i), .rect_top_i(top_i), .rect_width_i(wid_i),
    .rect_height_i(hgt_i), .rect_angle_i(ang_i), .done_i(done_o),
    .overlap_i(overlap_o), .fail_count_o(fail_count), .pending_o(pending),
    .hits_seen_o(hits_seen)
  );

  // Watchdog: end the run with a failure when the cycle budget runs out.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one request and hold start until busy is low at an edge.
  // start is left high; the caller lowers it only when a gap follows.
  // Fields arrive as 32-bit words and keep only their low bits.
  task automatic send_request(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] d, input logic [31:0] l,
                              input logic [31:0] t, input logic [31:0] w,
                              input logic [31:0] h, input logic [31:0] a);
    start_i <= 1'b1;
    cx_i <= cx[CoordBits-1:0]; cy_i <= cy[CoordBits-1:0]; diam_i <= d[SizeBits-1:0];
    left_i <= l[CoordBits-1:0]; top_i <= t[CoordBits-1:0];
    wid_i <= w[SizeBits-1:0]; hgt_i <= h[SizeBits-1:0]; ang_i <= a[TrigBits-1:0];
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    issued++;
  endtask

  // Drop start for a number of idle cycles.
  task automatic idle_for(input int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Random request: mostly a circle near a modest rectangle, sometimes full noise.
  task automatic random_request();
    int l, t, cx, cy, w, h, d;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 8) begin
      l = int'($urandom_range(0, 'hFFFFFF)) - 'h800000;
      l = l >>> $urandom_range(0, 12);
      t = int'($urandom_range(0, 'hFFFFFF)) - 'h800000;
      t = t >>> $urandom_range(0, 12);
      if (sel == 7) begin
        l = int'($urandom); t = int'($urandom);
      end
      w = int'($urandom_range(0, 1 << $urandom_range(0, 16)));
      h = int'($urandom_range(0, 1 << $urandom_range(0, 16)));
      d = int'($urandom_range(0, 1 << $urandom_range(0, 17)));
      cx = l + w / 2 + int'($urandom_range(0, 2 * (w + d) + 2)) - (w + d) / 2 - 1;
      cy = t + h / 2 + int'($urandom_range(0, 2 * (h + d) + 2)) - (h + d) / 2 - 1;
    end else begin
      cx = int'($urandom); cy = int'($urandom); l = int'($urandom); t = int'($urandom);
      w = int'($urandom); h = int'($urandom); d = int'($urandom);
    end
    send_request(cx, cy, d, l, t, w, h, $urandom);
  endtask

  initial begin
    logic [31:0] mn, mx;
    int burst;
    issued = 0;
    mn = 'h0080_0000;
    mx = 'h007F_FFFF;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every quadrant, zero sizes, far apart, zero diameter.
    send_request(0, 0, 256, 0, 0, 512, 512, 0);
    send_request(0, 0, 0, 0, 0, 512, 512, 0);
    send_request(0, 0, 256, 0, 0, 0, 0, 'h4000);
    send_request(100, 0, 512, 0, 0, 0, 512, 'h8000);
    send_request(0, 100, 512, 0, 0, 512, 0, 'hC000);
    send_request(mx, mx, '1, mn, mn, '1, '1, 'hFFFF);
    send_request(mn, mn, '1, mx, mx, '1, '1, 'h2000);
    send_request(mn, mx, '1, mn, mx, 0, 0, 'h6000);
    send_request(mx, mn, '1, mx, mn, '1, 0, 'hA000);
    send_request(mx, mx, 1, mn, mn, 0, 0, 'hE000);
    send_request(1024, 0, 256, 0, 0, 256, 256, 'h1234);
    send_request(-300, -300, 1000, 0, 0, 256, 256, 'h7FFF);
    send_request(0, 0, '1, 0, 0, '1, '1, 'h8001);
    send_request('h555555, 'hAAAAAA, 'h2AAAAA, 'hAAAAAA, 'h555555,
                 'h555555, 'h2AAAAA, 'h5555);
    send_request('hAAAAAA, 'h555555, 'h555555, 'h555555, 'hAAAAAA,
                 'h2AAAAA, 'h555555, 'hAAAA);

    // Pause until every expected result has come back.
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);

    // Random bursts of back-to-back requests; each burst is followed by an idle gap or not, at random.
    while (issued < RandomRequests + 15) begin
      burst = $urandom_range(1, 40);
      repeat (burst) random_request();
      if ($urandom_range(0, 1)) idle_for($urandom_range(1, 14));
    end
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    $display("Covered %0d requests (directed corners plus random near/far geometry).",
             issued);
    $display("Overlap flag seen set %0d times.", hits_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/crro_pkg.sv
hdl/crro_cordic_stage.sv
hdl/crro_backend.sv
hdl/circle_rotated_rect_overlap.sv
bench/circle_rotated_rect_overlap_chk.sv
bench/circle_rotated_rect_overlap_tb.sv
